[rtl/rec_pkg.sv]
package rec_pkg;

  // register map, byte address 4*index
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W = 5;

  localparam logic [REG_IDX_W-1:0] REG_CONE_MULT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ADDED_HT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SRC_COL     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC_ROW     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MISSING     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RASTER_W    = 3'd7;

  localparam logic [23:0] RST_CONE_MULT   = 24'd65536;
  localparam logic [31:0] RST_ADDED_HT    = 32'd0;
  localparam logic [12:0] RST_SRC_COL     = 13'h1FFF;
  localparam logic [16:0] RST_SRC_ROW     = 17'h1FFFF;
  localparam logic [31:0] RST_CELL_WIDTH  = 32'd65536;
  localparam logic [31:0] RST_CELL_HEIGHT = 32'd65536;
  localparam logic [31:0] RST_MISSING     = 32'hD8F1_0000;
  localparam logic [12:0] RST_RASTER_W    = 13'd256;

  localparam int ELEV_W = 32;
  localparam int VALUE_W = 31;
  localparam int SQ_IN_W = 64;
  localparam int SQ_OUT_W = 32;

  typedef struct packed {
    logic [23:0] cone_multiplier;
    logic [31:0] added_height;
    logic [12:0] source_column;
    logic [16:0] source_row;
    logic [31:0] cell_width;
    logic [31:0] cell_height;
    logic [31:0] missing_value;
    logic [12:0] raster_width;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_I,
    S_DIV_P,
    S_MUL_SI,
    S_SRC_CHK,
    S_RD_SRC,
    S_RD_E,
    S_GET_E,
    S_MUL_X,
    S_MUL_Y,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_SUM,
    S_SQRT,
    S_MUL_M,
    S_FIN,
    S_OUT
  } state_t;

endpackage

[rtl/rec_chan_if.sv]
interface rec_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] elevation;
  modport source (output valid, output command, output elevation, input ready);
  modport sink (input valid, input command, input elevation, output ready);
endinterface

interface rec_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] cone_value;
  logic        last_cell;
  modport source (output valid, output cone_value, output last_cell, input ready);
  modport sink (input valid, input cone_value, input last_cell, output ready);
endinterface

[rtl/raster_energy_cone_core.sv]
// Energy cone over an elevation raster.
// Load beat: taken while idle, ready stays high. Emit past the end: accepted, no output.
// Emit beat: one or two passes of the shared divider (cell, then peak coordinates when
// no source cell is set), the 32-step root unit and six turns of the shared 32x32
// multiplier (seven with a set source cell); a zero cone skips the root and later turns.
// Synchronous reset clears counters, peak search, sequencer and config; store is not cleared.
module raster_energy_cone_core #(
  parameter int MAX_CELLS = 65536,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  rec_in_if.sink                     in_ch,
  rec_out_if.source                  out_ch
);

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  // coordinates: signed, room for y and a configured row
  localparam int CRD_W = (CNT_W > 17 ? CNT_W : 17) + 1;
  localparam int DX_W = CRD_W + 1;
  localparam int TW = DX_W + 19;

  rec_pkg::cfg_t  cfg;
  rec_pkg::state_t state, state_next;

  // ---------------- config port
  rec_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // ---------------- raster state
  logic [CNT_W-1:0] loaded_count;
  logic [CNT_W-1:0] readout_index;
  logic [IDX_W-1:0] peak_index;
  logic signed [31:0] peak_elev;
  logic emitting;

  logic in_acc;
  logic is_load;
  logic [CNT_W-1:0] cnt_eff;
  logic load_ok;
  logic signed [31:0] in_elev;

  assign in_ch.ready = (state == rec_pkg::S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign is_load = !in_ch.command;
  assign in_elev = $signed(in_ch.elevation);
  // a load after readout starts a new raster
  assign cnt_eff = emitting ? '0 : loaded_count;
  assign load_ok = cnt_eff < CNT_W'(MAX_CELLS);

  // effective columns per row
  logic [WID_W-1:0] eff_w;
  always_comb begin
    if (cfg.raster_width == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(cfg.raster_width) > 32'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg.raster_width);
    end
  end

  logic cfg_src;
  assign cfg_src = !cfg.source_column[12] && !cfg.source_row[16];

  // ---------------- elevation store
  logic [IDX_W-1:0] rd_addr;
  logic [31:0] rd_data;

  rec_store #(.DEPTH(MAX_CELLS), .AW(IDX_W)) u_store (
    .clk(clk), .we(in_acc && is_load && load_ok), .waddr(cnt_eff[IDX_W-1:0]),
    .wdata(in_ch.elevation), .raddr(rd_addr), .rdata(rd_data)
  );

  // ---------------- shared divider: index -> (row, column)
  logic div_start, div_done;
  logic [CNT_W-1:0] div_dvd, div_q;
  logic [WID_W-1:0] div_r;

  rec_div #(.DVD_W(CNT_W), .DVS_W(WID_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(eff_w),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // ---------------- root unit
  logic sq_start, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;

  rec_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  // ---------------- datapath registers
  logic signed [CRD_W-1:0] cx, cy, sx, sy;
  logic signed [31:0] src_e;
  logic signed [33:0] dz;
  logic [CRD_W-1:0] dxm, dym;
  logic [31:0] ax, ay, az, radius;
  logic [63:0] acc, mul_q;
  logic [30:0] val_q;
  logic out_valid;
  logic [30:0] out_value;
  logic out_last;

  // shared multiplier, product registered every cycle
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (state)
      rec_pkg::S_MUL_SI: begin
        mul_a = {15'd0, cfg.source_row};
        mul_b = 32'(eff_w);
      end
      rec_pkg::S_MUL_X: begin
        mul_a = 32'(dxm);
        mul_b = cfg.cell_width;
      end
      rec_pkg::S_MUL_Y: begin
        mul_a = 32'(dym);
        mul_b = cfg.cell_height;
      end
      rec_pkg::S_SQ_X: begin
        mul_a = ax;
        mul_b = ax;
      end
      rec_pkg::S_SQ_Y: begin
        mul_a = ay;
        mul_b = ay;
      end
      rec_pkg::S_SQ_Z: begin
        mul_a = az;
        mul_b = az;
      end
      default: begin
        mul_a = {8'd0, cfg.cone_multiplier};
        mul_b = radius;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // source check: si = row*w + col against the loaded cells
  logic [63:0] si;
  logic si_in;
  assign si = mul_q + {51'd0, cfg.source_column};
  assign si_in = si < {{(64-CNT_W){1'b0}}, loaded_count};

  // cell terms, formed as the cell's elevation arrives
  logic signed [31:0] e_s;
  logic signed [32:0] h;
  logic signed [33:0] dz_c;
  logic signed [DX_W-1:0] dx, dy;
  logic signed [TW-1:0] tsum;
  logic cone_zero;
  logic [33:0] dz_mag;

  assign e_s = $signed(rd_data);
  assign h = 33'(src_e) + 33'($signed(cfg.added_height));
  assign dz_c = 34'(h) - 34'(e_s);
  assign dx = DX_W'(sx) - DX_W'(cx);
  assign dy = DX_W'(sy) - DX_W'(cy);
  // offsets count as whole metres against the height drop
  assign tsum = ((TW'(dx) + TW'(dy)) <<< 16) + TW'(dz_c);
  assign cone_zero = tsum[TW-1] || (tsum == '0);
  assign dz_mag = dz_c[33] ? 34'(-dz_c) : dz_c;

  // final value: dz - mult*d/2^16, clamped
  logic signed [41:0] val_c;
  logic [30:0] val_sat;
  assign val_c = 42'(dz) - $signed({2'b00, mul_q[55:16]});
  always_comb begin
    if (val_c[41]) begin
      val_sat = '0;
    end else if (|val_c[40:31]) begin
      val_sat = '1;
    end else begin
      val_sat = val_c[30:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ch.ready;

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rec_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_dvd = readout_index;
    sq_start = 1'b0;
    sq_in = sat_add(acc, mul_q);
    rd_addr = readout_index[IDX_W-1:0];
    case (state)
      rec_pkg::S_IDLE: begin
        if (in_acc && !is_load && readout_index < loaded_count) begin
          div_start = 1'b1;
          state_next = rec_pkg::S_DIV_I;
        end
      end
      rec_pkg::S_DIV_I: begin
        if (div_done) begin
          if (cfg_src) begin
            state_next = rec_pkg::S_MUL_SI;
          end else begin
            div_start = 1'b1;
            div_dvd = CNT_W'(peak_index);
            state_next = rec_pkg::S_DIV_P;
          end
        end
      end
      rec_pkg::S_DIV_P: begin
        if (div_done) begin
          state_next = rec_pkg::S_RD_E;
        end
      end
      rec_pkg::S_MUL_SI: state_next = rec_pkg::S_SRC_CHK;
      rec_pkg::S_SRC_CHK: begin
        if (si_in) begin
          rd_addr = si[IDX_W-1:0];
          state_next = rec_pkg::S_RD_SRC;
        end else begin
          state_next = rec_pkg::S_RD_E;
        end
      end
      rec_pkg::S_RD_SRC: state_next = rec_pkg::S_GET_E;
      rec_pkg::S_RD_E:   state_next = rec_pkg::S_GET_E;
      rec_pkg::S_GET_E:  state_next = cone_zero ? rec_pkg::S_OUT : rec_pkg::S_MUL_X;
      rec_pkg::S_MUL_X:  state_next = rec_pkg::S_MUL_Y;
      rec_pkg::S_MUL_Y:  state_next = rec_pkg::S_SQ_X;
      rec_pkg::S_SQ_X:   state_next = rec_pkg::S_SQ_Y;
      rec_pkg::S_SQ_Y:   state_next = rec_pkg::S_SQ_Z;
      rec_pkg::S_SQ_Z:   state_next = rec_pkg::S_SQ_SUM;
      rec_pkg::S_SQ_SUM: begin
        sq_start = 1'b1;
        state_next = rec_pkg::S_SQRT;
      end
      rec_pkg::S_SQRT: begin
        if (sq_done) begin
          state_next = rec_pkg::S_MUL_M;
        end
      end
      rec_pkg::S_MUL_M: state_next = rec_pkg::S_FIN;
      rec_pkg::S_FIN:   state_next = rec_pkg::S_OUT;
      rec_pkg::S_OUT: begin
        if (out_free) begin
          state_next = rec_pkg::S_IDLE;
        end
      end
      default: state_next = rec_pkg::S_IDLE;
    endcase
  end

  // ---------------- raster control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      readout_index <= '0;
      peak_index    <= '0;
      peak_elev     <= '0;
      emitting      <= 1'b0;
    end else begin
      if (in_acc && is_load) begin
        // new raster: count and peak restart through cnt_eff below
        if (emitting) begin
          emitting      <= 1'b0;
          readout_index <= '0;
        end
        if (load_ok) begin
          loaded_count <= cnt_eff + 1'b1;
          // first cell seeds the search; later ones must be strictly higher and not the missing value
          if (cnt_eff == '0) begin
            peak_elev  <= in_elev;
            peak_index <= '0;
          end else if (in_elev > peak_elev && in_ch.elevation != cfg.missing_value) begin
            peak_elev  <= in_elev;
            peak_index <= cnt_eff[IDX_W-1:0];
          end
        end
      end else if (in_acc) begin
        emitting <= 1'b1;
      end
      if (state == rec_pkg::S_OUT && out_free) begin
        readout_index <= readout_index + 1'b1;
      end
    end
  end

  // ---------------- per-cell datapath
  // each product lands in mul_q in the state after its operands are chosen
  always_ff @(posedge clk) begin
    case (state)
      rec_pkg::S_DIV_I: begin
        if (div_done) begin
          cx <= CRD_W'(div_r);
          cy <= CRD_W'(div_q);
          sx <= CRD_W'(cfg.source_column);
          sy <= CRD_W'(cfg.source_row);
        end
      end
      rec_pkg::S_DIV_P: begin
        if (div_done) begin
          sx    <= CRD_W'(div_r);
          sy    <= CRD_W'(div_q);
          src_e <= peak_elev;
        end
      end
      rec_pkg::S_SRC_CHK: begin
        // configured cell outside the loaded cells counts as height 0
        if (!si_in) begin
          src_e <= '0;
        end
      end
      rec_pkg::S_RD_SRC: src_e <= $signed(rd_data);
      rec_pkg::S_GET_E: begin
        dz    <= dz_c;
        dxm   <= dx[DX_W-1] ? CRD_W'(-dx) : CRD_W'(dx);
        dym   <= dy[DX_W-1] ? CRD_W'(-dy) : CRD_W'(dy);
        az    <= (|dz_mag[33:32]) ? 32'hFFFF_FFFF : dz_mag[31:0];
        val_q <= '0;
      end
      rec_pkg::S_MUL_Y:  ax  <= sat32(mul_q);
      rec_pkg::S_SQ_X:   ay  <= sat32(mul_q);
      rec_pkg::S_SQ_Y:   acc <= mul_q;
      rec_pkg::S_SQ_Z:   acc <= sat_add(acc, mul_q);
      rec_pkg::S_SQRT: begin
        if (sq_done) begin
          radius <= sq_root;
        end
      end
      rec_pkg::S_FIN:    val_q <= val_sat;
      default: ;
    endcase
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rec_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rec_pkg::S_OUT && out_free) begin
      out_value <= val_q;
      out_last  <= (readout_index + 1'b1) == loaded_count;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.cone_value = out_value;
  assign out_ch.last_cell  = out_last;

endmodule

[rtl/rec_regs.sv]
module rec_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rec_pkg::cfg_t              cfg
);

  logic [rec_pkg::REG_IDX_W-1:0] idx;
  logic wr;

  assign idx = paddr[rec_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cone_multiplier <= rec_pkg::RST_CONE_MULT;
      cfg.added_height    <= rec_pkg::RST_ADDED_HT;
      cfg.source_column   <= rec_pkg::RST_SRC_COL;
      cfg.source_row      <= rec_pkg::RST_SRC_ROW;
      cfg.cell_width      <= rec_pkg::RST_CELL_WIDTH;
      cfg.cell_height     <= rec_pkg::RST_CELL_HEIGHT;
      cfg.missing_value   <= rec_pkg::RST_MISSING;
      cfg.raster_width    <= rec_pkg::RST_RASTER_W;
    end else if (wr) begin
      case (idx)
        rec_pkg::REG_CONE_MULT:   cfg.cone_multiplier <= pwdata[23:0];
        rec_pkg::REG_ADDED_HT:    cfg.added_height    <= pwdata;
        rec_pkg::REG_SRC_COL:     cfg.source_column   <= pwdata[12:0];
        rec_pkg::REG_SRC_ROW:     cfg.source_row      <= pwdata[16:0];
        rec_pkg::REG_CELL_WIDTH:  cfg.cell_width      <= pwdata;
        rec_pkg::REG_CELL_HEIGHT: cfg.cell_height     <= pwdata;
        rec_pkg::REG_MISSING:     cfg.missing_value   <= pwdata;
        rec_pkg::REG_RASTER_W:    cfg.raster_width    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rec_pkg::REG_CONE_MULT:   prdata = {8'd0, cfg.cone_multiplier};
      rec_pkg::REG_ADDED_HT:    prdata = cfg.added_height;
      rec_pkg::REG_SRC_COL:     prdata = {{19{cfg.source_column[12]}}, cfg.source_column};
      rec_pkg::REG_SRC_ROW:     prdata = {{15{cfg.source_row[16]}}, cfg.source_row};
      rec_pkg::REG_CELL_WIDTH:  prdata = cfg.cell_width;
      rec_pkg::REG_CELL_HEIGHT: prdata = cfg.cell_height;
      rec_pkg::REG_MISSING:     prdata = cfg.missing_value;
      rec_pkg::REG_RASTER_W:    prdata = {19'd0, cfg.raster_width};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

[rtl/rec_store.sv]
module rec_store #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rec_pkg::ELEV_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [rec_pkg::ELEV_W-1:0]  rdata
);

  logic [rec_pkg::ELEV_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rec_div.sv]
module rec_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DVS_W:0] shifted;
  logic           fits;

  assign shifted = {rem, quot[DVD_W-1]};
  assign fits = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[DVD_W-2:0], fits};
      rem  <= fits ? DVS_W'(shifted - {1'b0, divisor}) : shifted[DVS_W-1:0];
    end
  end

endmodule

[rtl/rec_sqrt.sv]
module rec_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rec_pkg::SQ_IN_W-1:0]   radicand,
  output logic                          done,
  output logic [rec_pkg::SQ_OUT_W-1:0]  root
);

  localparam int RW = rec_pkg::SQ_OUT_W + 3;
  localparam int CW = $clog2(rec_pkg::SQ_OUT_W + 1);

  logic [rec_pkg::SQ_IN_W-1:0] rad;
  logic [RW-1:0] rem;
  logic [RW-1:0] r2;
  logic [RW-1:0] trial;
  logic [CW-1:0] cnt;
  logic          busy;

  assign r2 = {rem[RW-3:0], rad[rec_pkg::SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(rec_pkg::SQ_OUT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // two radicand bits, one root bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[rec_pkg::SQ_IN_W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root[rec_pkg::SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[rec_pkg::SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

endmodule
